@@ src/twsr_pkg.sv @@
// Shared constants, command and register codes, and control structs for the
// three-wheel speed ramp engine. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package twsr_pkg;

  // Fixed point: fraction bits of the ramp accumulator and step
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int SPD_W   = 8;   // signed wheel speed
  localparam int MAG_W   = 8;   // magnitude of a speed change
  localparam int ACC_W   = 32;  // ramp accumulator and step
  localparam int LEN_W   = 16;  // ramp length and step counter
  localparam int SLEW_W  = 8;   // slew rate register
  localparam int MAXS_W  = 7;   // max speed register
  localparam int CODE_W  = 8;   // power controller codes and bytes
  localparam int CMD_W   = 2;

  // Digit-serial accumulator: one byte per cycle
  localparam int DIG_W   = 8;
  localparam int NDIG    = ACC_W / DIG_W;

  // Bit-serial divider: dividend is |change| shifted up by FRAC_BITS
  localparam int DVW     = MAG_W + FRAC_BITS;
  localparam int REM_W   = LEN_W;

  // Shared sequencer counter covers the longest serial pass
  localparam int CNT_W   = $clog2(DVW);

  // Configuration port
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  // Stream payload widths
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = CMD_W;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SLEW   = 2'd1,
    CMD_DIRECT = 2'd2
  } cmd_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_DRIVE_ENABLE    = 3'd0,
    REG_CHARGING_ENABLE = 3'd1,
    REG_MAX_SPEED       = 3'd2,
    REG_SLEW_RATE       = 3'd3,
    REG_TIMEOUT_TICKS   = 3'd4,
    REG_CHARGE_IDLE     = 3'd5,
    REG_CHARGE_DONE     = 3'd6,
    REG_ALIGN_CODE      = 3'd7
  } cfg_reg_e;

  // Accumulator lane control
  typedef struct packed {
    logic load;   // take new accumulator and step values
    logic adv;    // add one digit and rotate
    logic start;  // first digit of a pass, carry in is zero
  } acc_ctl_t;

  // Divider lane control
  typedef struct packed {
    logic load;   // take new dividend and divisor
    logic adv;    // produce one quotient bit
  } div_ctl_t;

endpackage

@@ src/twsr_div.sv @@
// Bit-serial restoring divider lane: one quotient bit per cycle.
// Depends on twsr_pkg for widths and the control struct.
`timescale 1ns / 1ps

module twsr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  twsr_pkg::div_ctl_t            ctl_i,
  input  logic [twsr_pkg::MAG_W-1:0]    mag_i,
  input  logic [twsr_pkg::LEN_W-1:0]    divisor_i,
  output logic [twsr_pkg::DVW-1:0]      quo_o
);

  logic [twsr_pkg::DVW-1:0]   dvd_q;
  logic [twsr_pkg::REM_W-1:0] rem_q;
  logic [twsr_pkg::LEN_W-1:0] dvs_q;
  logic [twsr_pkg::REM_W:0]   rem_sh;
  logic [twsr_pkg::REM_W:0]   rem_sub;
  logic                       fits;

  // Shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh  = {rem_q, dvd_q[twsr_pkg::DVW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q <= '0;
      rem_q <= '0;
      dvs_q <= '0;
    end else if (ctl_i.load) begin
      dvd_q <= {mag_i, {twsr_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (ctl_i.adv) begin
      dvd_q <= {dvd_q[twsr_pkg::DVW-2:0], fits};
      rem_q <= fits ? rem_sub[twsr_pkg::REM_W-1:0] : rem_sh[twsr_pkg::REM_W-1:0];
    end
  end

  assign quo_o = dvd_q;

endmodule

@@ src/twsr_acc.sv @@
// Digit-serial ramp accumulator lane: adds the step one byte per cycle.
// Depends on twsr_pkg for widths and the control struct.
`timescale 1ns / 1ps

module twsr_acc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  twsr_pkg::acc_ctl_t            ctl_i,
  input  logic [twsr_pkg::ACC_W-1:0]    accum_init_i,
  input  logic [twsr_pkg::ACC_W-1:0]    step_init_i,
  output logic [twsr_pkg::ACC_W-1:0]    accum_o
);

  logic [twsr_pkg::ACC_W-1:0] accum_q;
  logic [twsr_pkg::ACC_W-1:0] step_q;
  logic                       carry_q;
  logic                       carry_in;
  logic [twsr_pkg::DIG_W:0]   dsum;

  // One digit of the add, carry taken from the previous digit
  always_comb begin
    carry_in = ctl_i.start ? 1'b0 : carry_q;
    dsum     = {1'b0, accum_q[twsr_pkg::DIG_W-1:0]}
             + {1'b0, step_q[twsr_pkg::DIG_W-1:0]}
             + {{twsr_pkg::DIG_W{1'b0}}, carry_in};
  end

  // Rotate both words by one digit; a full pass restores alignment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      step_q  <= '0;
      carry_q <= 1'b0;
    end else if (ctl_i.load) begin
      accum_q <= accum_init_i;
      step_q  <= step_init_i;
      carry_q <= 1'b0;
    end else if (ctl_i.adv) begin
      accum_q <= {dsum[twsr_pkg::DIG_W-1:0], accum_q[twsr_pkg::ACC_W-1:twsr_pkg::DIG_W]};
      step_q  <= {step_q[twsr_pkg::DIG_W-1:0], step_q[twsr_pkg::ACC_W-1:twsr_pkg::DIG_W]};
      carry_q <= dsum[twsr_pkg::DIG_W];
    end
  end

  assign accum_o = accum_q;

endmodule

@@ src/three_wheel_speed_ramp_with_timeout.sv @@
// Three-wheel speed ramp engine with command watchdog: top level sequencer.
// Depends on twsr_pkg, twsr_div and twsr_acc.
// One item at a time; a new beat is accepted only when the sequencer is idle.
// Tick: a ramp step uses a byte-serial add. Slew: shift-add multiply, then bit-serial
// divide; unchanged targets skip both. A tick that fires the watchdog in ramp mode
// can run a full slew before its ramp step.
// Output register frees the result path; a stalled result holds the next tick at emit.
// Reset (async, active low) loads register defaults and clears speeds, ramp and watchdog.
`timescale 1ns / 1ps

module three_wheel_speed_ramp_with_timeout (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [twsr_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  logic [twsr_pkg::CFG_DW-1:0]     cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // speed_a, speed_b, speed_c, bus_volts_raw, charge_state, align_byte
  input  logic [twsr_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic [twsr_pkg::S_USER_W-1:0]   s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // wheel_a, wheel_b, wheel_c, bus_volts, charge_block, charging_now, align_error, pad
  output logic [twsr_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // mode
  output logic [twsr_pkg::M_USER_W-1:0]   m_axis_tuser
);

  localparam int NW = 3;
  localparam logic [twsr_pkg::MAXS_W-1:0] MAX_SPEED_RST = 7'd127;
  localparam logic [twsr_pkg::SLEW_W-1:0] SLEW_RST      = 8'd1;
  localparam logic [twsr_pkg::LEN_W-1:0]  TIMEOUT_RST   = 16'd1000;
  localparam logic [twsr_pkg::CODE_W-1:0] DONE_CODE_RST = 8'd3;
  localparam logic [twsr_pkg::LEN_W-1:0]  CNT_SAT       = 16'hFFFF;
  localparam logic [twsr_pkg::CODE_W-1:0] VOLTS_NONE    = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WD,
    ST_DIRECT,
    ST_SLEW_CMP,
    ST_PLAN,
    ST_MUL,
    ST_DIVLD,
    ST_DIV,
    ST_FIN,
    ST_STEP,
    ST_ACC,
    ST_ACC_DONE,
    ST_EMIT
  } state_e;

  // configuration
  logic                          drive_en_q;
  logic                          chg_en_q;
  logic [twsr_pkg::MAXS_W-1:0]   max_speed_q;
  logic [twsr_pkg::SLEW_W-1:0]   slew_q;
  logic [twsr_pkg::LEN_W-1:0]    timeout_q;
  logic [twsr_pkg::CODE_W-1:0]   idle_code_q;
  logic [twsr_pkg::CODE_W-1:0]   done_code_q;
  logic [twsr_pkg::CODE_W-1:0]   align_code_q;

  // sequencer and ramp state
  state_e                        state_q;
  logic                          tick_q;
  logic [twsr_pkg::CNT_W-1:0]    cnt_q;
  logic [twsr_pkg::SPD_W-1:0]    cur_q [NW];
  logic [twsr_pkg::SPD_W-1:0]    tgt_q [NW];
  logic [twsr_pkg::SPD_W-1:0]    t_q   [NW];
  logic [twsr_pkg::MAG_W-1:0]    mag_q [NW];
  logic                          neg_q [NW];
  logic [twsr_pkg::LEN_W-1:0]    len_q;
  logic [twsr_pkg::LEN_W-1:0]    ramp_cnt_q;
  logic                          mode_q;
  logic [twsr_pkg::LEN_W-1:0]    idle_q;

  // serial multiplier
  logic [twsr_pkg::LEN_W-1:0]    mcand_q;
  logic [twsr_pkg::SLEW_W-1:0]   mplier_q;
  logic [twsr_pkg::LEN_W-1:0]    prod_q;

  // captured tick side fields
  logic [twsr_pkg::CODE_W-1:0]   raw_q;
  logic [twsr_pkg::CODE_W-1:0]   cs_q;
  logic [twsr_pkg::CODE_W-1:0]   algn_q;

  // result register
  logic                          m_valid_q;
  logic [twsr_pkg::M_DATA_W-1:0] m_data_q;
  logic                          m_mode_q;

  // lane wiring
  twsr_pkg::acc_ctl_t            acc_ctl;
  twsr_pkg::div_ctl_t            div_ctl;
  logic [twsr_pkg::ACC_W-1:0]    acc_init [NW];
  logic [twsr_pkg::ACC_W-1:0]    step_init [NW];
  logic [twsr_pkg::ACC_W-1:0]    acc_w [NW];
  logic [twsr_pkg::DVW-1:0]      quo_w [NW];

  // combinational helpers
  logic [twsr_pkg::SPD_W-1:0]    clamp_w [NW];
  logic signed [twsr_pkg::SPD_W:0] diff_w [NW];
  logic [twsr_pkg::MAG_W-1:0]    big_w;
  logic                          same_tgt;
  logic [twsr_pkg::LEN_W-1:0]    idle_nx;
  logic                          charging;
  logic                          gate;
  logic [twsr_pkg::SPD_W-1:0]    wheel_w [NW];
  logic [twsr_pkg::CODE_W-1:0]   volts_w;
  logic                          in_acc;
  twsr_pkg::cmd_e                cmd_w;

  function automatic logic [twsr_pkg::SPD_W-1:0] clamp_spd(
    input logic [twsr_pkg::SPD_W-1:0]  v,
    input logic [twsr_pkg::MAXS_W-1:0] m
  );
    logic signed [twsr_pkg::SPD_W:0] sv;
    logic signed [twsr_pkg::SPD_W:0] sm;
    logic signed [twsr_pkg::SPD_W:0] nm;
    logic [twsr_pkg::SPD_W-1:0]      r;
    begin
      sv = (twsr_pkg::SPD_W+1)'(signed'(v));
      sm = signed'({2'b00, m});
      nm = -sm;
      r  = v;
      if (sv < nm) begin
        r = nm[twsr_pkg::SPD_W-1:0];
      end else if (sv > sm) begin
        r = sm[twsr_pkg::SPD_W-1:0];
      end
      return r;
    end
  endfunction

  // Clamp the incoming speeds per lane
  always_comb begin
    clamp_w[0] = clamp_spd(s_axis_tdata[7:0],   max_speed_q);
    clamp_w[1] = clamp_spd(s_axis_tdata[15:8],  max_speed_q);
    clamp_w[2] = clamp_spd(s_axis_tdata[23:16], max_speed_q);
  end

  // Speed change per lane and the unchanged-target check
  always_comb begin
    same_tgt = 1'b1;
    for (int i = 0; i < NW; i++) begin
      diff_w[i] = (twsr_pkg::SPD_W+1)'(signed'(t_q[i]))
                - (twsr_pkg::SPD_W+1)'(signed'(cur_q[i]));
      if (t_q[i] != tgt_q[i]) begin
        same_tgt = 1'b0;
      end
    end
  end

  // Largest change magnitude
  always_comb begin
    big_w = mag_q[0];
    if (mag_q[1] > big_w) begin
      big_w = mag_q[1];
    end
    if (mag_q[2] > big_w) begin
      big_w = mag_q[2];
    end
  end

  // Ramp plan values: start at the current speed, signed step from the divider
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      acc_init[i] = twsr_pkg::ACC_W'(signed'(cur_q[i])) << twsr_pkg::FRAC_BITS;
      if (prod_q == '0) begin
        step_init[i] = '0;
      end else if (neg_q[i]) begin
        step_init[i] = -twsr_pkg::ACC_W'(quo_w[i]);
      end else begin
        step_init[i] = twsr_pkg::ACC_W'(quo_w[i]);
      end
    end
  end

  // Lane control from the sequencer state
  always_comb begin
    acc_ctl.load  = (state_q == ST_FIN) && !same_tgt;
    acc_ctl.adv   = (state_q == ST_ACC);
    acc_ctl.start = (cnt_q == '0);
    div_ctl.load  = (state_q == ST_DIVLD);
    div_ctl.adv   = (state_q == ST_DIV);
  end

  for (genvar g = 0; g < NW; g++) begin : g_lane
    twsr_div u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (div_ctl),
      .mag_i     (mag_q[g]),
      .divisor_i (prod_q),
      .quo_o     (quo_w[g])
    );

    twsr_acc u_acc (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (acc_ctl),
      .accum_init_i (acc_init[g]),
      .step_init_i  (step_init[g]),
      .accum_o      (acc_w[g])
    );
  end

  // Result fields from the captured status bytes
  always_comb begin
    idle_nx  = idle_q + 1'b1;
    charging = (cs_q != idle_code_q) && (cs_q != done_code_q);
    gate     = !drive_en_q || charging;
    volts_w  = (raw_q == '0) ? VOLTS_NONE : raw_q;
    for (int i = 0; i < NW; i++) begin
      wheel_w[i] = gate ? '0 : cur_q[i];
    end
    in_acc   = s_axis_tvalid && s_axis_tready;
    cmd_w    = twsr_pkg::cmd_e'(s_axis_tuser);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_en_q   <= 1'b1;
      chg_en_q     <= 1'b0;
      max_speed_q  <= MAX_SPEED_RST;
      slew_q       <= SLEW_RST;
      timeout_q    <= TIMEOUT_RST;
      idle_code_q  <= '0;
      done_code_q  <= DONE_CODE_RST;
      align_code_q <= '0;
    end else if (cfg_we_i) begin
      unique case (twsr_pkg::cfg_reg_e'(cfg_addr_i))
        twsr_pkg::REG_DRIVE_ENABLE:    drive_en_q   <= cfg_data_i[0];
        twsr_pkg::REG_CHARGING_ENABLE: chg_en_q     <= cfg_data_i[0];
        twsr_pkg::REG_MAX_SPEED:       max_speed_q  <= cfg_data_i[twsr_pkg::MAXS_W-1:0];
        twsr_pkg::REG_SLEW_RATE:       slew_q       <= cfg_data_i[twsr_pkg::SLEW_W-1:0];
        twsr_pkg::REG_TIMEOUT_TICKS:   timeout_q    <= cfg_data_i[twsr_pkg::LEN_W-1:0];
        twsr_pkg::REG_CHARGE_IDLE:     idle_code_q  <= cfg_data_i[twsr_pkg::CODE_W-1:0];
        twsr_pkg::REG_CHARGE_DONE:     done_code_q  <= cfg_data_i[twsr_pkg::CODE_W-1:0];
        twsr_pkg::REG_ALIGN_CODE:      align_code_q <= cfg_data_i[twsr_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: command dispatch, watchdog, ramp planning, ramp step, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tick_q     <= 1'b0;
      cnt_q      <= '0;
      len_q      <= '0;
      ramp_cnt_q <= 16'd1;
      mode_q     <= 1'b0;
      idle_q     <= '0;
      mcand_q    <= '0;
      mplier_q   <= '0;
      prod_q     <= '0;
      raw_q      <= '0;
      cs_q       <= '0;
      algn_q     <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_mode_q   <= 1'b0;
      for (int i = 0; i < NW; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
        t_q[i]   <= '0;
        mag_q[i] <= '0;
        neg_q[i] <= 1'b0;
      end
    end else begin
      // drop the result once taken
      if (m_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < NW; i++) begin
              t_q[i] <= clamp_w[i];
            end
            raw_q  <= s_axis_tdata[31:24];
            cs_q   <= s_axis_tdata[39:32];
            algn_q <= s_axis_tdata[47:40];
            tick_q <= 1'b0;
            unique case (cmd_w)
              twsr_pkg::CMD_TICK:   state_q <= ST_WD;
              twsr_pkg::CMD_SLEW:   state_q <= ST_SLEW_CMP;
              twsr_pkg::CMD_DIRECT: state_q <= ST_DIRECT;
              default:              state_q <= ST_IDLE;
            endcase
          end
        end

        // advance the watchdog; on timeout command zero in the current mode
        ST_WD: begin
          tick_q <= 1'b1;
          if (idle_nx == timeout_q) begin
            idle_q <= '0;
            if (!mode_q) begin
              for (int i = 0; i < NW; i++) begin
                t_q[i] <= '0;
              end
              state_q <= ST_SLEW_CMP;
            end else begin
              for (int i = 0; i < NW; i++) begin
                cur_q[i] <= '0;
              end
              state_q <= ST_STEP;
            end
          end else begin
            idle_q  <= idle_nx;
            state_q <= ST_STEP;
          end
        end

        ST_DIRECT: begin
          mode_q <= 1'b1;
          idle_q <= '0;
          for (int i = 0; i < NW; i++) begin
            cur_q[i] <= t_q[i];
          end
          state_q <= ST_IDLE;
        end

        // hold the plan when the targets are unchanged
        ST_SLEW_CMP: begin
          mode_q <= 1'b0;
          idle_q <= '0;
          if (same_tgt) begin
            state_q <= tick_q ? ST_STEP : ST_IDLE;
          end else begin
            for (int i = 0; i < NW; i++) begin
              neg_q[i] <= diff_w[i][twsr_pkg::SPD_W];
              mag_q[i] <= diff_w[i][twsr_pkg::SPD_W]
                        ? twsr_pkg::MAG_W'(-diff_w[i])
                        : twsr_pkg::MAG_W'(diff_w[i]);
            end
            state_q <= ST_PLAN;
          end
        end

        ST_PLAN: begin
          mcand_q  <= twsr_pkg::LEN_W'(big_w);
          mplier_q <= slew_q;
          prod_q   <= '0;
          cnt_q    <= '0;
          state_q  <= ST_MUL;
        end

        // shift-add multiply: ramp length = largest change * slew rate
        ST_MUL: begin
          if (mplier_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          if (cnt_q == twsr_pkg::CNT_W'(twsr_pkg::SLEW_W - 1)) begin
            state_q <= ST_DIVLD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        ST_DIVLD: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end

        ST_DIV: begin
          if (cnt_q == twsr_pkg::CNT_W'(twsr_pkg::DVW - 1)) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        // commit the new ramp
        ST_FIN: begin
          len_q      <= prod_q;
          ramp_cnt_q <= '0;
          for (int i = 0; i < NW; i++) begin
            tgt_q[i] <= t_q[i];
          end
          state_q <= tick_q ? ST_STEP : ST_IDLE;
        end

        ST_STEP: begin
          cnt_q <= '0;
          if (ramp_cnt_q < len_q) begin
            state_q <= ST_ACC;
          end else begin
            if (ramp_cnt_q == len_q) begin
              for (int i = 0; i < NW; i++) begin
                cur_q[i] <= tgt_q[i];
              end
              if (ramp_cnt_q != CNT_SAT) begin
                ramp_cnt_q <= ramp_cnt_q + 1'b1;
              end
            end
            state_q <= ST_EMIT;
          end
        end

        ST_ACC: begin
          if (cnt_q == twsr_pkg::CNT_W'(twsr_pkg::NDIG - 1)) begin
            state_q <= ST_ACC_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        // take the integer part of each accumulator
        ST_ACC_DONE: begin
          for (int i = 0; i < NW; i++) begin
            cur_q[i] <= acc_w[i][twsr_pkg::FRAC_BITS +: twsr_pkg::SPD_W];
          end
          if (ramp_cnt_q != CNT_SAT) begin
            ramp_cnt_q <= ramp_cnt_q + 1'b1;
          end
          state_q <= ST_EMIT;
        end

        // load the result register once it is free
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_mode_q  <= mode_q;
            m_data_q  <= {5'b00000,
                          (algn_q != align_code_q),
                          charging,
                          !chg_en_q,
                          volts_w,
                          wheel_w[2],
                          wheel_w[1],
                          wheel_w[0]};
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_mode_q;

  // step counter only moves down when a new ramp is committed
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FIN) |=> (ramp_cnt_q >= $past(ramp_cnt_q)))
    else $error("ramp step counter went down outside a ramp commit");

  // a slew command always clears the watchdog and leaves direct mode
  a_slew_wd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SLEW_CMP) |=> (idle_q == '0) && !mode_q)
    else $error("slew did not clear watchdog or mode");

  // direct mode is entered only by a direct command
  a_mode_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mode_q) |-> ($past(state_q) == ST_DIRECT))
    else $error("mode set outside a direct command");

  // emit completes into a valid result and frees the input side
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!m_valid_q || m_axis_tready)) |=>
      (m_valid_q && state_q == ST_IDLE))
    else $error("tick result was not presented");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the three-wheel speed ramp engine: a directed stimulus table,
// then random phases under several register settings, scored by an in-bench
// predictor. Depends on twsr_pkg and three_wheel_speed_ramp_with_timeout.
`timescale 1ns / 1ps

module tb_top;
  import twsr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 95;
  localparam int PRESSURE_PHASE = 4;
  localparam int SETTLE_CYCLES  = 80;   // longer than a watchdog-fired slew
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 4000;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [SPD_W-1:0] spd_a, spd_b, spd_c;
    logic [CODE_W-1:0]       volts_raw, chg_state, align_byte;
  } in_beat_t;

  typedef struct packed {
    logic                    mode;
    logic signed [SPD_W-1:0] wheel_a, wheel_b, wheel_c;
    logic [CODE_W-1:0]       bus_volts;
    logic                    charge_block, charging_now, align_error;
  } tick_res_t;

  typedef struct packed {
    logic               drive_en, chg_en;
    logic [MAXS_W-1:0]  max_spd;
    logic [SLEW_W-1:0]  slew;
    logic [LEN_W-1:0]   timeout;
    logic [CODE_W-1:0]  idle_code, done_code, align_code;
  } cfg_set_t;

  typedef struct {
    in_beat_t  it;
    bit        typed;
    tick_res_t want;
  } dir_row_t;

  localparam cfg_set_t CFG_DEFAULT =
    '{1'b1, 1'b0, 7'd127, 8'd1, 16'd1000, 8'd0, 8'd3, 8'd0};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr_i    = '0;
  logic [CFG_DW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [S_USER_W-1:0] s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;

  // Predictor copy of the registers and the ramp state
  cfg_set_t                cfg_now;
  logic signed [SPD_W-1:0] cur_spd [3];
  logic signed [SPD_W-1:0] tgt_spd [3];
  logic [ACC_W-1:0]        ramp_acc [3];
  logic [ACC_W-1:0]        ramp_inc [3];
  logic [LEN_W-1:0]        ramp_len, ramp_cnt, idle_cnt;
  logic                    drv_mode;

  tick_res_t tick_frames_due [$];
  dir_row_t  dir_rows [$];
  int        bad_frames   = 0;
  int        stall_cycles = 0;
  bit        hold_req     = 1'b0;

  three_wheel_speed_ramp_with_timeout i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_spd(int v);
    int m;
    m = int'(cfg_now.max_spd);
    if (v < -m) v = -m;
    if (v > m) v = m;
    return v;
  endfunction

  // Plan a linear ramp from the present speeds to the clamped targets
  function automatic void plan_ramp(int a, int b, int c);
    int               t [3];
    int               diff [3];
    int               big;
    longint           num;
    longint           quo;
    logic [LEN_W-1:0] steps;
    drv_mode = 1'b0;
    idle_cnt = '0;
    t[0] = clamp_spd(a);
    t[1] = clamp_spd(b);
    t[2] = clamp_spd(c);
    // same targets as before: keep the running ramp
    if (t[0] == int'(tgt_spd[0]) && t[1] == int'(tgt_spd[1]) && t[2] == int'(tgt_spd[2]))
      return;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = t[i] - int'(cur_spd[i]);
      if (diff[i] > big) big = diff[i];
      if (-diff[i] > big) big = -diff[i];
    end
    steps = LEN_W'(big * int'(cfg_now.slew));
    ramp_len = steps;
    for (int i = 0; i < 3; i++) begin
      num = longint'(diff[i]) * (longint'(1) << FRAC_BITS);
      // a zero-length ramp gets zero increments and snaps on the next tick
      quo = (steps != 0) ? num / longint'(steps) : longint'(0);
      tgt_spd[i]  = SPD_W'(t[i]);
      ramp_inc[i] = ACC_W'(quo);
      ramp_acc[i] = ACC_W'(longint'(cur_spd[i]) * (longint'(1) << FRAC_BITS));
    end
    ramp_cnt = '0;
  endfunction

  function automatic void apply_direct(int a, int b, int c);
    drv_mode   = 1'b1;
    idle_cnt   = '0;
    cur_spd[0] = SPD_W'(clamp_spd(a));
    cur_spd[1] = SPD_W'(clamp_spd(b));
    cur_spd[2] = SPD_W'(clamp_spd(c));
  endfunction

  // Advance the predictor by one accepted beat; return 1 when it yields a frame
  function automatic bit step_drive(input in_beat_t it, output tick_res_t res);
    bit charging;
    bit gate;
    res = '0;
    if (it.cmd == CMD_SLEW) begin
      plan_ramp(int'($signed(it.spd_a)), int'($signed(it.spd_b)), int'($signed(it.spd_c)));
      return 1'b0;
    end
    if (it.cmd == CMD_DIRECT) begin
      apply_direct(int'($signed(it.spd_a)), int'($signed(it.spd_b)),
                   int'($signed(it.spd_c)));
      return 1'b0;
    end
    if (it.cmd != CMD_TICK) return 1'b0;

    // watchdog: wraps at 16 bits, commands zero in the current mode
    idle_cnt = idle_cnt + 1'b1;
    if (idle_cnt == cfg_now.timeout) begin
      if (drv_mode == 1'b0) plan_ramp(0, 0, 0);
      else apply_direct(0, 0, 0);
      idle_cnt = '0;
    end

    // one ramp step, or the final snap to the targets
    if (ramp_cnt <= ramp_len) begin
      for (int i = 0; i < 3; i++) begin
        if (ramp_cnt < ramp_len) begin
          ramp_acc[i] = ramp_acc[i] + ramp_inc[i];
          cur_spd[i]  = ramp_acc[i][FRAC_BITS +: SPD_W];
        end else begin
          cur_spd[i] = tgt_spd[i];
        end
      end
      if (ramp_cnt != '1) ramp_cnt = ramp_cnt + 1'b1;
    end

    charging = (it.chg_state != cfg_now.idle_code) && (it.chg_state != cfg_now.done_code);
    gate     = !cfg_now.drive_en || charging;
    res.mode         = drv_mode;
    res.wheel_a      = gate ? '0 : cur_spd[0];
    res.wheel_b      = gate ? '0 : cur_spd[1];
    res.wheel_c      = gate ? '0 : cur_spd[2];
    res.bus_volts    = (it.volts_raw == '0) ? 8'd255 : it.volts_raw;
    res.charge_block = !cfg_now.chg_en;
    res.charging_now = charging;
    res.align_error  = it.align_byte != cfg_now.align_code;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_row(logic [CMD_W-1:0] cmd, int a, int b, int c, int raw,
                                  int cs, int al, bit typed = 1'b0, tick_res_t want = '0);
    dir_row_t row;
    row.it.cmd        = cmd;
    row.it.spd_a      = SPD_W'(a);
    row.it.spd_b      = SPD_W'(b);
    row.it.spd_c      = SPD_W'(c);
    row.it.volts_raw  = CODE_W'(raw);
    row.it.chg_state  = CODE_W'(cs);
    row.it.align_byte = CODE_W'(al);
    row.typed         = typed;
    row.want          = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [SPD_W-1:0] pick_speed();
    int m;
    m = int'(cfg_now.max_spd);
    case ($urandom_range(0, 7))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return SPD_W'(m);
      3:       return SPD_W'(-m);
      4:       return SPD_W'(m + 1);
      5, 6:    return SPD_W'(int'($urandom_range(0, 12)) - 6);
      default: return SPD_W'($urandom);
    endcase
  endfunction

  function automatic in_beat_t pick_item(logic [CMD_W-1:0] cmd);
    in_beat_t it;
    it.cmd        = cmd;
    it.spd_a      = pick_speed();
    it.spd_b      = pick_speed();
    it.spd_c      = pick_speed();
    it.volts_raw  = ($urandom_range(0, 7) == 0) ? 8'd0 : CODE_W'($urandom);
    case ($urandom_range(0, 2))
      0:       it.chg_state = cfg_now.idle_code;
      1:       it.chg_state = cfg_now.done_code;
      default: it.chg_state = CODE_W'($urandom);
    endcase
    it.align_byte = ($urandom_range(0, 3) != 0) ? cfg_now.align_code : CODE_W'($urandom);
    return it;
  endfunction

  function automatic cfg_set_t phase_config(int p);
    cfg_set_t c;
    case (p)
      0: c = '{1'b1, 1'b1, 7'd127, 8'd1, 16'd5, 8'd0, 8'd3, 8'd0};
      1: c = '{1'b0, 1'b0, 7'd0, 8'd255, 16'd65535, 8'd255, 8'd255, 8'd255};
      2: c = '{1'b1, 1'b1, 7'd1, 8'd0, 16'd1, 8'h55, 8'hAA, 8'h0F};
      3: c = '{1'b1, 1'b0, 7'd100, 8'd2, 16'd0, 8'h10, 8'h20, 8'hF0};
      default: begin
        c.drive_en   = ($urandom_range(0, 7) != 0);
        c.chg_en     = 1'($urandom_range(0, 1));
        c.max_spd    = ($urandom_range(0, 2) == 0) ? 7'd127 : MAXS_W'($urandom);
        c.slew       = SLEW_W'($urandom_range(1, 3));
        c.timeout    = LEN_W'($urandom_range(2, 24));
        c.idle_code  = CODE_W'($urandom);
        c.done_code  = CODE_W'($urandom);
        c.align_code = CODE_W'($urandom);
      end
    endcase
    return c;
  endfunction

  // Offer one beat, wait for the handshake, then idle for a random gap
  task automatic send_item(input in_beat_t it, input bit typed, input tick_res_t want);
    tick_res_t res;
    int        gap;
    int        r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.align_byte, it.chg_state, it.volts_raw, it.spd_c, it.spd_b, it.spd_a};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (step_drive(it, res)) tick_frames_due.push_back(typed ? want : res);
    r = $urandom_range(0, 99);
    if (r < 55)      gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else             gap = $urandom_range(20, 60);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input logic [CMD_W-1:0] cmd, input int count, inout int n);
    for (int k = 0; k < count; k++) begin
      send_item(pick_item(cmd), 1'b0, '0);
      if (cmd != CMD_UNUSED) n++;
    end
  endtask

  // Drop valid, drain all pending frames, then let any silent work finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tick_frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_set_t c);
    logic [CFG_DW-1:0] vals [8];
    vals[REG_DRIVE_ENABLE]    = CFG_DW'(c.drive_en);
    vals[REG_CHARGING_ENABLE] = CFG_DW'(c.chg_en);
    vals[REG_MAX_SPEED]       = CFG_DW'(c.max_spd);
    vals[REG_SLEW_RATE]       = CFG_DW'(c.slew);
    vals[REG_TIMEOUT_TICKS]   = c.timeout;
    vals[REG_CHARGE_IDLE]     = CFG_DW'(c.idle_code);
    vals[REG_CHARGE_DONE]     = CFG_DW'(c.done_code);
    vals[REG_ALIGN_CODE]      = CFG_DW'(c.align_code);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_now = c;
  endtask

  initial begin : stimulus
    int kind;
    int n;
    int run;
    cfg_now  = CFG_DEFAULT;
    for (int i = 0; i < 3; i++) begin
      cur_spd[i]  = '0;
      tgt_spd[i]  = '0;
      ramp_acc[i] = '0;
      ramp_inc[i] = '0;
    end
    ramp_len = '0;
    ramp_cnt = 16'd1;
    idle_cnt = '0;
    drv_mode = 1'b0;

    // Directed table, register defaults after reset
    add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 1'b1,
            tick_res_t'{1'b0, 8'sd0, 8'sd0, 8'sd0, 8'd255, 1'b1, 1'b0, 1'b0});
    add_row(CMD_TICK, -128, 127, -1, 255, 3, 255, 1'b1,
            tick_res_t'{1'b0, 8'sd0, 8'sd0, 8'sd0, 8'd255, 1'b1, 1'b0, 1'b1});
    add_row(CMD_TICK, 127, -128, 0, 1, 128, 0, 1'b1,
            tick_res_t'{1'b0, 8'sd0, 8'sd0, 8'sd0, 8'd1, 1'b1, 1'b1, 1'b0});
    add_row(CMD_SLEW, 127, -128, 0, 8'hAA, 8'h55, 8'hFF);
    add_row(CMD_TICK, 0, 0, 0, 100, 0, 0);
    add_row(CMD_TICK, 0, 0, 0, 7, 3, 0);
    add_row(CMD_TICK, 0, 0, 0, 50, 2, 0);
    // same targets again: ramp keeps running
    add_row(CMD_SLEW, 127, -128, 0, 0, 0, 0);
    add_row(CMD_TICK, 0, 0, 0, 60, 0, 0);
    // direct command in the middle of a ramp
    add_row(CMD_DIRECT, -128, 127, 5, 0, 0, 0);
    add_row(CMD_TICK, 0, 0, 0, 61, 0, 0);
    add_row(CMD_UNUSED, 1, 2, 3, 4, 5, 6);
    add_row(CMD_TICK, 0, 0, 0, 62, 3, 0);
    add_row(CMD_SLEW, 0, 0, 0, 0, 0, 0);
    add_row(CMD_TICK, 0, 0, 0, 63, 0, 0);
    // zero-length ramp: targets already reached by a direct command
    add_row(CMD_DIRECT, 3, 3, 3, 0, 0, 0);
    add_row(CMD_SLEW, 3, 3, 3, 0, 0, 0);
    add_row(CMD_TICK, 0, 0, 0, 64, 0, 0);
    add_row(CMD_TICK, 0, 0, 0, 65, 0, 0);
    add_row(CMD_SLEW, -3, -3, -3, 0, 0, 0);
    for (int k = 0; k < 5; k++) add_row(CMD_TICK, 0, 0, 0, 66 + k, 0, 8'h01 << k);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Random phases: mostly ramp runs of up to 40 ticks, plus direct runs,
    // watchdog runs and single noise beats
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      load_config(phase_config(p));
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          send_run(CMD_SLEW, 1, n);
          run = int'(ramp_len) + 2;
          if (run > 40) run = 40;
          send_run(CMD_TICK, run, n);
        end else if (kind < 7) begin
          send_run(CMD_DIRECT, 1, n);
          send_run(CMD_TICK, $urandom_range(1, 4), n);
        end else if (kind < 8) begin
          run = int'(cfg_now.timeout) + 1;
          if (run > 30 || cfg_now.timeout == '0) run = 30;
          send_run(CMD_TICK, run, n);
        end else begin
          send_run(CMD_W'($urandom_range(0, 3)), 1, n);
        end
      end
    end

    settle();
    if (bad_frames == 0) $display("[three_wheel_speed_ramp_with_timeout] OK");
    else $display("[three_wheel_speed_ramp_with_timeout] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // Random backpressure; a requested hold keeps tready low for a long stretch
  initial begin : result_sink
    int span;
    int r;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold_req = 1'b0;
        span = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          m_axis_tready <= 1'b1;
          span = $urandom_range(1, 12);
        end else if (r < 55) begin
          m_axis_tready <= 1'b1;
          span = $urandom_range(40, 120);
        end else if (r < 92) begin
          m_axis_tready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          m_axis_tready <= 1'b0;
          span = $urandom_range(10, 40);
        end
      end
      repeat (span) @(posedge clk_i);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_frames++;
    end
  endfunction

  // Score each result beat against the oldest pending frame
  always @(posedge clk_i) begin : frame_check
    tick_res_t got;
    tick_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.mode         = m_axis_tuser[0];
      got.wheel_a      = m_axis_tdata[7:0];
      got.wheel_b      = m_axis_tdata[15:8];
      got.wheel_c      = m_axis_tdata[23:16];
      got.bus_volts    = m_axis_tdata[31:24];
      got.charge_block = m_axis_tdata[32];
      got.charging_now = m_axis_tdata[33];
      got.align_error  = m_axis_tdata[34];
      if (tick_frames_due.size() == 0) begin
        $error("result beat with no tick pending");
        bad_frames++;
      end else begin
        want = tick_frames_due.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("wheel_a", want.wheel_a, got.wheel_a);
        check_field("wheel_b", want.wheel_b, got.wheel_b);
        check_field("wheel_c", want.wheel_c, got.wheel_c);
        check_field("bus_volts", want.bus_volts, got.bus_volts);
        check_field("charge_block", want.charge_block, got.charge_block);
        check_field("charging_now", want.charging_now, got.charging_now);
        check_field("align_error", want.align_error, got.align_error);
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin : stall_watch
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[three_wheel_speed_ramp_with_timeout] ERROR");
      $finish;
    end
  end

endmodule
